[design/pt_pkg.sv]
// pt_pkg: widths, register indexes, reset values, control structs and the
// saturation helper shared by the perceptron trainer modules.
// No dependencies.
package pt_pkg;

  localparam int MAX_LANES = 8;
  localparam int X_W       = 16;
  localparam int W_W       = 32;
  localparam int PROD_W    = W_W + X_W;
  localparam int SCL_W     = X_W + 17;
  localparam int UPD_W     = W_W + 3;
  localparam int LS_W      = 16;
  localparam int AF_W      = 4;
  localparam int MC_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd1;

  localparam logic [LS_W-1:0] LS_RESET = 16'd655;
  localparam logic [AF_W-1:0] AF_RESET = 4'd8;

  typedef logic signed [X_W-1:0]    feat_t;
  typedef logic signed [W_W-1:0]    weight_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic mul_en;
    logic upd_en;
    logic alpha_pos;
  } lane_ctl_t;

  typedef struct packed {
    logic add1_en;
    logic add2_en;
  } merge_ctl_t;

  // clamp a widened sum back into the signed 32-bit range
  function automatic weight_t sat_w(input logic signed [UPD_W-1:0] v);
    logic signed [UPD_W-1:0] hi;
    logic signed [UPD_W-1:0] lo;
    hi = UPD_W'(signed'({1'b0, {(W_W-1){1'b1}}}));
    lo = -hi - UPD_W'(1);
    if (v > hi) begin
      return weight_t'(hi);
    end else if (v < lo) begin
      return weight_t'(lo);
    end else begin
      return weight_t'(v);
    end
  endfunction

endpackage

[design/pt_ifs.sv]
// pt_ifs: valid/ready channel interfaces for input and result words.
// Depends on pt_pkg.
interface pt_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  pt_pkg::feat_t       feature_0;
  pt_pkg::feat_t       feature_1;
  pt_pkg::feat_t       feature_2;
  pt_pkg::feat_t       feature_3;
  pt_pkg::feat_t       feature_4;
  pt_pkg::feat_t       feature_5;
  pt_pkg::feat_t       feature_6;
  pt_pkg::feat_t       feature_7;
  logic                expected_positive;
  logic                last_in_pass;

  modport source (
    output valid, kind, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7,
           expected_positive, last_in_pass,
    input  ready
  );
  modport sink (
    input  valid, kind, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7,
           expected_positive, last_in_pass,
    output ready
  );
endinterface

interface pt_out_if;
  logic                     valid;
  logic                     ready;
  logic                     predicted_positive;
  logic                     weights_changed;
  logic [pt_pkg::MC_W-1:0]  pass_mistakes;

  modport source (
    output valid, predicted_positive, weights_changed, pass_mistakes,
    input  ready
  );
  modport sink (
    input  valid, predicted_positive, weights_changed, pass_mistakes,
    output ready
  );
endinterface

[design/pt_lane.sv]
// pt_lane: one feature lane; holds its weight, forms w*x for the score and
// learn_step*x for the update, then applies the saturating update.
// Depends on pt_pkg.
module pt_lane #(
  parameter int LANE = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pt_pkg::lane_ctl_t           ctl,
  input  logic [pt_pkg::AF_W-1:0]     active_features,
  input  logic [pt_pkg::LS_W-1:0]     learn_step,
  input  pt_pkg::feat_t               x,
  output pt_pkg::prod_t               prod
);
  import pt_pkg::*;

  weight_t                  w_r;
  weight_t                  w_nxt;
  prod_t                    prod_r;
  logic signed [SCL_W-1:0]  scl_r;
  logic                     active;
  logic signed [UPD_W-1:0]  twice;
  logic signed [UPD_W-1:0]  delta;

  assign active = (AF_W'(LANE) < active_features);

  // alpha is +-2, so the update is +-(2*ls*x) floored by 2^12
  always_comb begin
    twice = {{(UPD_W-SCL_W-1){scl_r[SCL_W-1]}}, scl_r, 1'b0};
    if (!ctl.alpha_pos) begin
      twice = -twice;
    end
    delta = twice >>> 12;
    w_nxt = sat_w(UPD_W'(w_r) + delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else if (ctl.upd_en && active) begin
      w_r <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= active ? (prod_t'(w_r) * prod_t'(x)) : '0;
      scl_r  <= SCL_W'($signed({1'b0, learn_step})) * SCL_W'(x);
    end
  end

  assign prod = prod_r;

endmodule

[design/pt_merge.sv]
// pt_merge: two-level registered adder tree over the lane products and the
// scaled bias, ending in the strict sign test of the score.
// Depends on pt_pkg.
module pt_merge (
  input  logic             clk,
  input  pt_pkg::merge_ctl_t ctl,
  input  pt_pkg::prod_t    prods [pt_pkg::MAX_LANES],
  input  pt_pkg::weight_t  bias,
  output logic             pred_pos
);
  import pt_pkg::*;

  localparam int PAIRS = MAX_LANES / 2;
  localparam int SUM_W = PROD_W + 4;

  logic signed [PROD_W:0]   pair_r [PAIRS];
  logic signed [SUM_W-1:0]  bias_r;
  logic signed [SUM_W-1:0]  total;
  logic                     pred_r;

  always_comb begin
    total = bias_r;
    for (int p = 0; p < PAIRS; p++) begin
      total = total + SUM_W'(pair_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add1_en) begin
      for (int p = 0; p < PAIRS; p++) begin
        pair_r[p] <= (PROD_W+1)'(prods[2*p]) + (PROD_W+1)'(prods[2*p+1]);
      end
      bias_r <= SUM_W'(bias) <<< 12;
    end
    if (ctl.add2_en) begin
      pred_r <= (total > 0);
    end
  end

  assign pred_pos = pred_r;

endmodule

[design/perceptron_trainer.sv]
// Online perceptron trainer: an item is taken in the idle state, lanes multiply in
// the next state, the adder tree runs in states ADD1 and ADD2, and the update state
// loads the result register, waiting while an earlier result is still held; a new
// item is taken only once the update is done and the trainer is idle again.
// Reset clears bias, weights and mistake count at once and restores
// learn_step 655 and active_features 8; there is no clearing pass.
module perceptron_trainer #(
  parameter int FEATURES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pt_in_if.sink                         in_ch,
  pt_out_if.source                      out_ch,
  input  logic                          cfg_we,
  input  logic [pt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pt_pkg::CFG_W-1:0]      cfg_data
);
  import pt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ADD1 = 5'b00100,
    S_ADD2 = 5'b01000,
    S_UPD  = 5'b10000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [LS_W-1:0]     learn_step_r;
  logic [AF_W-1:0]     active_r;
  feat_t               x_r [MAX_LANES];
  logic                kind_r;
  logic                exp_r;
  logic                last_r;
  weight_t             bias_r;
  weight_t             bias_nxt;
  logic [MC_W-1:0]     mc_r;
  logic [MC_W-1:0]     mc_inc;
  logic                out_valid_r;
  logic                out_pred_r;
  logic                out_chg_r;
  logic [MC_W-1:0]     out_mc_r;
  logic                accept;
  logic                finish;
  logic                pred_pos;
  logic                mistake;
  prod_t               prods [MAX_LANES];
  lane_ctl_t           lane_ctl;
  merge_ctl_t          merge_ctl;
  logic signed [UPD_W-1:0] step;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  // the update waits while an earlier result is still held
  assign finish      = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign mistake     = kind_r && (pred_pos != exp_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD1;
      S_ADD1:  state_nxt = S_ADD2;
      S_ADD2:  state_nxt = S_UPD;
      S_UPD:   if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_step_r <= LS_RESET;
      active_r     <= AF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEARN_STEP) begin
        learn_step_r <= cfg_data[LS_W-1:0];
      end else if (cfg_index == CFG_ACTIVE) begin
        active_r <= cfg_data[AF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r[0] <= in_ch.feature_0;
      x_r[1] <= in_ch.feature_1;
      x_r[2] <= in_ch.feature_2;
      x_r[3] <= in_ch.feature_3;
      x_r[4] <= in_ch.feature_4;
      x_r[5] <= in_ch.feature_5;
      x_r[6] <= in_ch.feature_6;
      x_r[7] <= in_ch.feature_7;
      kind_r <= in_ch.kind;
      exp_r  <= in_ch.expected_positive;
      last_r <= in_ch.last_in_pass;
    end
  end

  assign lane_ctl.mul_en    = (state_r == S_MUL);
  assign lane_ctl.upd_en    = finish && mistake;
  assign lane_ctl.alpha_pos = exp_r;
  assign merge_ctl.add1_en  = (state_r == S_ADD1);
  assign merge_ctl.add2_en  = (state_r == S_ADD2);

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    if (i < FEATURES) begin : g_on
      pt_lane #(.LANE(i)) u_lane (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (lane_ctl),
        .active_features (active_r),
        .learn_step      (learn_step_r),
        .x               (x_r[i]),
        .prod            (prods[i])
      );
    end else begin : g_off
      assign prods[i] = '0;
    end
  end

  pt_merge u_merge (
    .clk      (clk),
    .ctl      (merge_ctl),
    .prods    (prods),
    .bias     (bias_r),
    .pred_pos (pred_pos)
  );

  always_comb begin
    step = UPD_W'($signed({1'b0, learn_step_r, 1'b0}));
    if (!exp_r) begin
      step = -step;
    end
    bias_nxt = sat_w(UPD_W'(bias_r) + step);
    mc_inc   = (mistake && (mc_r != '1)) ? mc_r + MC_W'(1) : mc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r      <= '0;
      mc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        if (mistake) begin
          bias_r <= bias_nxt;
        end
        mc_r        <= last_r ? '0 : mc_inc;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_pred_r <= pred_pos;
      out_chg_r  <= mistake;
      out_mc_r   <= last_r ? mc_inc : '0;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.predicted_positive = out_pred_r;
  assign out_ch.weights_changed    = out_chg_r;
  assign out_ch.pass_mistakes      = out_mc_r;

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for perceptron_trainer, directed table then
// randomized training passes, checked against an in-bench perceptron predictor.
// Depends on pt_pkg, pt_ifs (pt_in_if, pt_out_if) and the perceptron_trainer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 205;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_TRAIN   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [X_W-1:0] X_MAX = 16'h7FFF;
  localparam logic [X_W-1:0] X_MIN = 16'h8000;
  localparam logic [MC_W-1:0] MISS_TOP = 16'hFFFF;

  typedef struct packed {
    logic                          kind;
    logic [MAX_LANES-1:0][X_W-1:0] x;
    logic                          exp_pos;
    logic                          last;
  } word_t;

  typedef struct packed {
    logic            pred;
    logic            chg;
    logic [MC_W-1:0] mis;
  } verdict_t;

  typedef struct packed {
    word_t    w;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam int DIR_N = 21;
  localparam row_t DIR_ROWS [DIR_N] = '{
    '{'{KIND_PREDICT, {8{16'h0000}}, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{KIND_PREDICT, {8{X_MAX}},    1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{KIND_TRAIN,   {8{X_MIN}},    1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{KIND_TRAIN,   {8{X_MAX}},    1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 16'd0}},
    '{'{KIND_TRAIN,   {8{X_MIN}},    1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, 16'd0}},
    '{'{KIND_TRAIN,   {8{X_MAX}},    1'b1, 1'b1}, 1'b0, '0},
    '{'{KIND_PREDICT, {8{X_MIN}},    1'b0, 1'b1}, 1'b0, '0},
    '{'{KIND_TRAIN,   {4{X_MAX, X_MIN}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {4{X_MIN, X_MAX}}, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'hFFFF}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'h0001}}, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {4{16'h5555, 16'hAAAA}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'hAAAA}}, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'h5555}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_PREDICT, {8{16'h1000}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {112'h0, X_MAX}, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {X_MIN, 112'h0}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'h0000}}, 1'b1, 1'b0}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'h0000}}, 1'b0, 1'b1}, 1'b0, '0},
    '{'{KIND_PREDICT, {8{X_MAX}},    1'b0, 1'b1}, 1'b0, '0},
    '{'{KIND_TRAIN,   {8{16'h0FFF}}, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pt_in_if  in_ch ();
  pt_out_if out_ch ();

  perceptron_trainer #(.FEATURES(MAX_LANES)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state: bias at index 0, lane weights above
  logic signed [W_W-1:0] m_wt [MAX_LANES+1];
  logic [LS_W-1:0] m_step;
  logic [AF_W-1:0] m_active;
  logic [MC_W-1:0] m_miss;

  verdict_t pending_verdicts [$];
  logic     row_typed;
  verdict_t row_want;

  int unsigned cycle_count;
  int          mismatches;
  bit          quiet;

  // hidden separating plane used to label training words
  int tgt [MAX_LANES];
  int tgt_bias;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [W_W-1:0] sat_sum(input logic signed [W_W-1:0] a,
                                                    input longint d);
    longint s;
    s = longint'(a) + d;
    if (s > longint'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -longint'(32'sh7FFF_FFFF) - 1) begin
      return 32'sh8000_0000;
    end
    return s[W_W-1:0];
  endfunction

  function automatic verdict_t classify_and_train(input word_t w);
    longint   acc;
    longint   step;
    int       lanes;
    verdict_t r;
    lanes = (int'(m_active) > MAX_LANES) ? MAX_LANES : int'(m_active);
    acc = longint'(m_wt[0]) * 4096;
    for (int i = 0; i < lanes; i++) begin
      acc += longint'(m_wt[i+1]) * longint'($signed(w.x[i]));
    end
    r.pred = (acc > 0);
    r.chg = 1'b0;
    r.mis = '0;
    if (w.kind == KIND_TRAIN && r.pred != w.exp_pos) begin
      step = (w.exp_pos ? 2 : -2) * longint'(m_step);
      m_wt[0] = sat_sum(m_wt[0], step);
      for (int i = 0; i < lanes; i++) begin
        // arithmetic shift floors toward minus infinity
        m_wt[i+1] = sat_sum(m_wt[i+1], (step * longint'($signed(w.x[i]))) >>> 12);
      end
      r.chg = 1'b1;
      if (m_miss != MISS_TOP) m_miss++;
    end
    if (w.last) begin
      r.mis = m_miss;
      m_miss = '0;
    end
    return r;
  endfunction

  function automatic logic target_class(input word_t w);
    longint acc;
    acc = longint'(tgt_bias) * 4096;
    for (int i = 0; i < MAX_LANES; i++) begin
      acc += longint'(tgt[i]) * longint'($signed(w.x[i]));
    end
    return acc > 0;
  endfunction

  function automatic logic [X_W-1:0] pick_feature();
    logic [X_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = X_MIN;
      1: v = X_MAX;
      2: v = '0;
      3: v = 16'hFFFF;
      4, 5: v = 16'($urandom_range(0, 8191)) - 16'd4096;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic compare_verdict(input verdict_t got, input verdict_t want);
    if (got.pred !== want.pred)
      flag_mismatch($sformatf("predicted_positive got %0b want %0b", got.pred, want.pred));
    if (got.chg !== want.chg)
      flag_mismatch($sformatf("weights_changed got %0b want %0b", got.chg, want.chg));
    if (got.mis !== want.mis)
      flag_mismatch($sformatf("pass_mistakes got %0d want %0d", got.mis, want.mis));
  endtask

  always @(posedge clk) begin : scoreboard
    word_t    w;
    verdict_t got;
    verdict_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst_n) begin
      for (int i = 0; i <= MAX_LANES; i++) m_wt[i] = '0;
      m_step = LS_RESET;
      m_active = AF_RESET;
      m_miss = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEARN_STEP) m_step = cfg_data[LS_W-1:0];
        else if (cfg_index == CFG_ACTIVE) m_active = cfg_data[AF_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.predicted_positive, out_ch.weights_changed, out_ch.pass_mistakes};
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("result word with nothing pending");
        end else begin
          want = pending_verdicts.pop_front();
          compare_verdict(got, want);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w = {in_ch.kind, in_ch.feature_7, in_ch.feature_6, in_ch.feature_5,
             in_ch.feature_4, in_ch.feature_3, in_ch.feature_2, in_ch.feature_1,
             in_ch.feature_0, in_ch.expected_positive, in_ch.last_in_pass};
        want = classify_and_train(w);
        if (row_typed) want = row_want;
        pending_verdicts.push_back(want);
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_word(input word_t w, input logic typed, input verdict_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= w.kind;
    in_ch.feature_0 <= w.x[0];
    in_ch.feature_1 <= w.x[1];
    in_ch.feature_2 <= w.x[2];
    in_ch.feature_3 <= w.x[3];
    in_ch.feature_4 <= w.x[4];
    in_ch.feature_5 <= w.x[5];
    in_ch.feature_6 <= w.x[6];
    in_ch.feature_7 <= w.x[7];
    in_ch.expected_positive <= w.exp_pos;
    in_ch.last_in_pass <= w.last;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait until every pending result word is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    word_t          w;
    int             remaining;
    int             pass_len;
    bit             noisy;
    logic [LS_W-1:0] ph_step [PHASES];
    logic [AF_W-1:0] ph_act [PHASES];

    quiet = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= 1'b0;
    in_ch.feature_0 <= '0;
    in_ch.feature_1 <= '0;
    in_ch.feature_2 <= '0;
    in_ch.feature_3 <= '0;
    in_ch.feature_4 <= '0;
    in_ch.feature_5 <= '0;
    in_ch.feature_6 <= '0;
    in_ch.feature_7 <= '0;
    in_ch.expected_positive <= 1'b0;
    in_ch.last_in_pass <= 1'b0;
    row_typed <= 1'b0;
    row_want <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table runs on the reset settings
    for (int r = 0; r < DIR_N; r++) begin
      send_word(DIR_ROWS[r].w, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    settle();
    // an unmapped index must leave both registers alone
    write_reg(CFG_SPARE, 16'hFFFF);

    ph_step = '{16'hFFFF, 16'd0, 16'd1, 16'd12345, 16'd40000, 16'd300,
                16'($urandom()), LS_RESET};
    ph_act  = '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5,
                4'($urandom_range(1, 8)), AF_RESET};

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_LEARN_STEP, ph_step[p]);
      write_reg(CFG_ACTIVE, {12'd0, ph_act[p]});
      for (int i = 0; i < MAX_LANES; i++) tgt[i] = int'($urandom_range(0, 2000)) - 1000;
      tgt_bias = int'($urandom_range(0, 16000)) - 8000;
      remaining = PHASE_ITEMS;
      while (remaining > 0) begin
        pass_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
        quiet = ($urandom_range(0, 4) == 0);
        noisy = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) settle();
        for (int k = 0; k < pass_len && remaining > 0; k++) begin
          w.kind = ($urandom_range(0, 4) == 0) ? KIND_PREDICT : KIND_TRAIN;
          for (int i = 0; i < MAX_LANES; i++) w.x[i] = pick_feature();
          if (noisy || $urandom_range(0, 9) == 0) w.exp_pos = 1'($urandom_range(0, 1));
          else w.exp_pos = target_class(w);
          w.last = (k == pass_len - 1) || (remaining == 1) || ($urandom_range(0, 19) == 0);
          send_word(w, 1'b0, '0);
          remaining--;
        end
      end
    end
    quiet = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[perceptron_trainer.f]
design/pt_pkg.sv
design/pt_ifs.sv
design/pt_lane.sv
design/pt_merge.sv
design/perceptron_trainer.sv
bench/tb_top.sv
